FILE: sv/pli_pkg.sv
// Shared types, widths and codes for the positional list block.
// No dependencies; every other file uses this package by scoped names.
package pli_pkg;

    localparam int DEPTH       = 64;   // list capacity, 2 to 64
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int POS_W       = 7;
    localparam int ST_W        = 2;
    localparam int ENTRY_IDX_W = 6;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = $clog2(DEPTH);

    // command opcodes
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE  = 2'd2;
    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd3;

    // result status
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    // per-cell operation broadcast along the chain
    localparam logic [2:0] CELL_HOLD   = 3'd0;
    localparam logic [2:0] CELL_INSERT = 3'd1;
    localparam logic [2:0] CELL_DELETE = 3'd2;
    localparam logic [2:0] CELL_UPDATE = 3'd3;
    localparam logic [2:0] CELL_ROTATE = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  count;
        logic [DATA_W-1:0] value;
    } pli_ctl_t;

endpackage

FILE: sv/pli_cmd_if.sv
// Command channel: valid/ready handshake with opcode, position and value.
// Depends on pli_pkg.
interface pli_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [pli_pkg::OP_W-1:0]     opcode;
    logic [pli_pkg::POS_W-1:0]    position;
    logic signed [pli_pkg::DATA_W-1:0] value;

    modport source (output valid, opcode, position, value, input ready);
    modport sink   (input valid, opcode, position, value, output ready);
endinterface

FILE: sv/pli_rsp_if.sv
// Result channel: valid/ready handshake with status and display payload.
// Depends on pli_pkg.
interface pli_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [pli_pkg::ST_W-1:0]          status;
    logic signed [pli_pkg::DATA_W-1:0] entry_value;
    logic [pli_pkg::ENTRY_IDX_W-1:0]   entry_index;
    logic [pli_pkg::POS_W-1:0]         length_after;
    logic                              last;

    modport source (output valid, status, entry_value, entry_index, length_after, last,
                    input ready);
    modport sink   (input valid, status, entry_value, entry_index, length_after, last,
                    output ready);
endinterface

FILE: sv/pli_cell.sv
// One list slot: holds an entry and takes its neighbor's value on shifts.
// Depends on pli_pkg.
module pli_cell
(
    input  logic                       clk,
    input  pli_pkg::pli_ctl_t          ctl,
    input  logic [pli_pkg::POS_W-1:0]  idx,
    input  logic [pli_pkg::DATA_W-1:0] left_data,
    input  logic [pli_pkg::DATA_W-1:0] right_data,
    input  logic [pli_pkg::DATA_W-1:0] head_data,
    output logic [pli_pkg::DATA_W-1:0] data
);

    logic [pli_pkg::DATA_W-1:0] data_reg;
    logic [pli_pkg::DATA_W-1:0] data_next;
    logic [pli_pkg::POS_W-1:0]  idx_p1;

    assign idx_p1 = idx + pli_pkg::POS_W'(1);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            pli_pkg::CELL_INSERT:
            begin
                if (idx == ctl.pos)
                    data_next = ctl.value;
                else if (idx > ctl.pos && idx <= ctl.count)
                    data_next = left_data;
            end
            pli_pkg::CELL_DELETE:
            begin
                if (idx >= ctl.pos && idx_p1 < ctl.count)
                    data_next = right_data;
            end
            pli_pkg::CELL_UPDATE:
            begin
                if (idx == ctl.pos)
                    data_next = ctl.value;
            end
            pli_pkg::CELL_ROTATE:
            begin
                // live entries circulate toward the head, head wraps to the tail
                if (idx_p1 < ctl.count)
                    data_next = right_data;
                else if (idx_p1 == ctl.count)
                    data_next = head_data;
            end
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: sv/positional_list_insert_delete.sv
// Positional list: insert/delete/update one transaction per cycle unless stalled.
// Display of n entries: after a setup step, one result per cycle unless stalled, with
// the cell chain rotating one place per emitted entry toward the head.
// Empty display gives a single result.
// rst_n (async, active low) clears the count, FSM and output valid; entries
// are not reset and are only read after being written.
module positional_list_insert_delete
(
    input  logic     clk,
    input  logic     rst_n,
    pli_cmd_if.sink  cmd,
    pli_rsp_if.source rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DISP = 1'b1;

    // control and output registers
    logic                               state_reg, state_next;
    logic [pli_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [pli_pkg::IDX_W-1:0]          disp_idx_reg, disp_idx_next;
    logic                               ovalid_reg, ovalid_next;
    logic [pli_pkg::ST_W-1:0]           ostatus_reg, ostatus_next;
    logic [pli_pkg::DATA_W-1:0]         ovalue_reg, ovalue_next;
    logic [pli_pkg::ENTRY_IDX_W-1:0]    oindex_reg, oindex_next;
    logic [pli_pkg::POS_W-1:0]          olen_reg, olen_next;
    logic                               olast_reg, olast_next;

    logic                               out_free;
    logic                               accept;
    logic [pli_pkg::POS_W-1:0]          cnt_ext;
    logic                               disp_last;
    pli_pkg::pli_ctl_t                  ctl;
    logic [pli_pkg::DATA_W-1:0]         cell_data [pli_pkg::DEPTH];

    // output register frees when empty or when its transaction completes
    assign out_free  = !ovalid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;
    assign cnt_ext   = pli_pkg::POS_W'(count_reg);
    assign disp_last = (pli_pkg::POS_W'(disp_idx_reg) + pli_pkg::POS_W'(1)) == cnt_ext;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        disp_idx_next = disp_idx_reg;
        ovalid_next   = ovalid_reg && !rsp.ready;
        ostatus_next  = ostatus_reg;
        ovalue_next   = ovalue_reg;
        oindex_next   = oindex_reg;
        olen_next     = olen_reg;
        olast_next    = olast_reg;
        ctl.op        = pli_pkg::CELL_HOLD;
        ctl.pos       = cmd.position;
        ctl.count     = cnt_ext;
        ctl.value     = cmd.value;

        if (state_reg == S_IDLE)
        begin
            if (accept)
            begin
                ostatus_next = pli_pkg::ST_OK;
                ovalue_next  = '0;
                oindex_next  = '0;
                olast_next   = 1'b1;
                ovalid_next  = 1'b1;
                case (cmd.opcode)
                    pli_pkg::OP_INSERT:
                    begin
                        if (cmd.position > cnt_ext)
                            ostatus_next = pli_pkg::ST_BAD;
                        else if (cnt_ext == pli_pkg::POS_W'(pli_pkg::DEPTH))
                            ostatus_next = pli_pkg::ST_FULL;
                        else
                        begin
                            ctl.op     = pli_pkg::CELL_INSERT;
                            count_next = count_reg + pli_pkg::CNT_W'(1);
                        end
                    end
                    pli_pkg::OP_DELETE:
                    begin
                        if (cmd.position >= cnt_ext)
                            ostatus_next = pli_pkg::ST_BAD;
                        else
                        begin
                            ctl.op     = pli_pkg::CELL_DELETE;
                            count_next = count_reg - pli_pkg::CNT_W'(1);
                        end
                    end
                    pli_pkg::OP_UPDATE:
                    begin
                        if (cmd.position >= cnt_ext)
                            ostatus_next = pli_pkg::ST_BAD;
                        else
                            ctl.op = pli_pkg::CELL_UPDATE;
                    end
                    pli_pkg::OP_DISPLAY:
                    begin
                        if (count_reg == '0)
                            ostatus_next = pli_pkg::ST_EMPTY;
                        else
                        begin
                            // stream from the head starting next cycle
                            ovalid_next   = 1'b0;
                            state_next    = S_DISP;
                            disp_idx_next = '0;
                        end
                    end
                    default:
                        ostatus_next = pli_pkg::ST_BAD;
                endcase
                olen_next = pli_pkg::POS_W'(count_next);
            end
        end
        else
        begin
            // display: emit the head cell and rotate the chain by one
            if (out_free)
            begin
                ctl.op        = pli_pkg::CELL_ROTATE;
                ovalid_next   = 1'b1;
                ostatus_next  = pli_pkg::ST_OK;
                ovalue_next   = cell_data[0];
                oindex_next   = pli_pkg::ENTRY_IDX_W'(disp_idx_reg);
                olen_next     = cnt_ext;
                olast_next    = disp_last;
                disp_idx_next = disp_idx_reg + pli_pkg::IDX_W'(1);
                if (disp_last)
                    state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            disp_idx_reg <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            disp_idx_reg <= disp_idx_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        ostatus_reg <= ostatus_next;
        ovalue_reg  <= ovalue_next;
        oindex_reg  <= oindex_next;
        olen_reg    <= olen_next;
        olast_reg   <= olast_next;
    end

    // chain of list cells; cell 0 is the list head
    for (genvar g = 0; g < pli_pkg::DEPTH; g++)
    begin : g_cell
        logic [pli_pkg::DATA_W-1:0] left_d;
        logic [pli_pkg::DATA_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == pli_pkg::DEPTH - 1)
        begin : g_tail
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        pli_cell u_cell
        (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (pli_pkg::POS_W'(g)),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[g])
        );
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = ostatus_reg;
    assign rsp.entry_value  = ovalue_reg;
    assign rsp.entry_index  = oindex_reg;
    assign rsp.length_after = olen_reg;
    assign rsp.last         = olast_reg;

endmodule

FILE: sv/pli_checker.sv
// Port-level checks on the positional list result stream, bound to the top.
// Depends on pli_pkg and positional_list_insert_delete.
module pli_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [pli_pkg::ST_W-1:0]          rsp_status,
    input logic [pli_pkg::ENTRY_IDX_W-1:0]   rsp_entry_index,
    input logic [pli_pkg::POS_W-1:0]         rsp_length_after,
    input logic                              rsp_last
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last))
        else $error("result changed while stalled");

    // only display streams produce non-final results, all with ok status
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> rsp_status == pli_pkg::ST_OK)
        else $error("non-final result without ok status");

    // non-final display entries lie below the last index
    a_mid_idx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |->
            (pli_pkg::POS_W'(rsp_entry_index) + pli_pkg::POS_W'(1)) < rsp_length_after)
        else $error("display index out of range");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == pli_pkg::ST_EMPTY |-> rsp_length_after == '0 && rsp_last)
        else $error("empty status with entries held");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == pli_pkg::ST_FULL |->
            rsp_length_after == pli_pkg::POS_W'(pli_pkg::DEPTH))
        else $error("full status on a list that is not full");

endmodule

bind positional_list_insert_delete pli_checker u_pli_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_entry_index  (rsp.entry_index),
    .rsp_length_after (rsp.length_after),
    .rsp_last         (rsp.last)
);

FILE: sim/pli_list_checker.sv
`timescale 1ns / 100ps
// Checker for the positional list: it watches the command and result channels and
// predicts every result. It uses pli_pkg and the pli_cmd_if / pli_rsp_if interfaces.
module pli_list_checker
(
    input  logic clk,
    input  logic rst_n,
    pli_cmd_if   cmd,
    pli_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding,
    output int   results_checked
);

    typedef struct packed {
        logic [pli_pkg::ST_W-1:0]          status;
        logic signed [pli_pkg::DATA_W-1:0] entry_value;
        logic [pli_pkg::ENTRY_IDX_W-1:0]   entry_index;
        logic [pli_pkg::POS_W-1:0]         length_after;
        logic                              last;
    } list_result_t;

    logic signed [pli_pkg::DATA_W-1:0] list_mirror [pli_pkg::DEPTH];
    int unsigned                       mirror_len;
    list_result_t                      pending_results [$];
    int                                error_total;
    int                                checked_total;

    assign fail_count      = error_total;
    assign results_checked = checked_total;

    initial
    begin
        error_total   = 0;
        checked_total = 0;
        mirror_len    = 0;
    end

    // Applies one command to the mirror and queues the results it should give.
    task automatic apply_command(input logic [pli_pkg::OP_W-1:0] op,
                                 input logic [pli_pkg::POS_W-1:0] pos,
                                 input logic signed [pli_pkg::DATA_W-1:0] val);
        list_result_t               res;
        logic [pli_pkg::ST_W-1:0]   outcome;
        int unsigned                at;
        res     = '0;
        outcome = pli_pkg::ST_OK;
        at      = 32'(pos);
        if (op == pli_pkg::OP_DISPLAY)
        begin
            if (mirror_len == 0)
            begin
                res.status = pli_pkg::ST_EMPTY;
                res.last   = 1'b1;
                pending_results.push_back(res);
            end
            else
            begin
                for (int i = 0; i < mirror_len; i++)
                begin
                    res.status       = pli_pkg::ST_OK;
                    res.entry_value  = list_mirror[i];
                    res.entry_index  = pli_pkg::ENTRY_IDX_W'(i);
                    res.length_after = pli_pkg::POS_W'(mirror_len);
                    res.last         = (i == mirror_len - 1);
                    pending_results.push_back(res);
                end
            end
        end
        else
        begin
            case (op)
                pli_pkg::OP_INSERT:
                begin
                    if (at > mirror_len)
                        outcome = pli_pkg::ST_BAD;
                    else if (mirror_len >= pli_pkg::DEPTH)
                        outcome = pli_pkg::ST_FULL;
                    else
                    begin
                        for (int i = mirror_len; i > at; i--)
                            list_mirror[i] = list_mirror[i-1];
                        list_mirror[at] = val;
                        mirror_len++;
                    end
                end
                pli_pkg::OP_DELETE:
                begin
                    if (at >= mirror_len)
                        outcome = pli_pkg::ST_BAD;
                    else
                    begin
                        for (int i = at; i + 1 < mirror_len; i++)
                            list_mirror[i] = list_mirror[i+1];
                        mirror_len--;
                    end
                end
                default:
                begin
                    if (at >= mirror_len)
                        outcome = pli_pkg::ST_BAD;
                    else
                        list_mirror[at] = val;
                end
            endcase
            res.status       = outcome;
            res.length_after = pli_pkg::POS_W'(mirror_len);
            res.last         = 1'b1;
            pending_results.push_back(res);
        end
    endtask

    task automatic flag_field(input string field, input logic [pli_pkg::DATA_W-1:0] want,
                              input logic [pli_pkg::DATA_W-1:0] got);
        error_total++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        list_result_t want;
        if (!rst_n)
        begin
            mirror_len = 0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first: a command accepted on this edge cannot answer on it
            if (rsp.valid && rsp.ready)
            begin
                checked_total++;
                if (pending_results.size() == 0)
                begin
                    error_total++;
                    $display({"%0t: unexpected result, status %0h value %0h",
                              " index %0d len %0d last %0b"},
                             $time, rsp.status, rsp.entry_value, rsp.entry_index,
                             rsp.length_after, rsp.last);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.status !== want.status)
                        flag_field("status", pli_pkg::DATA_W'(want.status),
                                   pli_pkg::DATA_W'(rsp.status));
                    if (rsp.entry_value !== want.entry_value)
                        flag_field("entry_value", want.entry_value, rsp.entry_value);
                    if (rsp.entry_index !== want.entry_index)
                        flag_field("entry_index", pli_pkg::DATA_W'(want.entry_index),
                                   pli_pkg::DATA_W'(rsp.entry_index));
                    if (rsp.length_after !== want.length_after)
                        flag_field("length_after", pli_pkg::DATA_W'(want.length_after),
                                   pli_pkg::DATA_W'(rsp.length_after));
                    if (rsp.last !== want.last)
                        flag_field("last", pli_pkg::DATA_W'(want.last),
                                   pli_pkg::DATA_W'(rsp.last));
                end
            end
            if (cmd.valid && cmd.ready)
                apply_command(cmd.opcode, cmd.position, cmd.value);
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: sim/tb_positional_list_insert_delete.sv
`timescale 1ns / 100ps
// Top of the positional list testbench: clock, reset, command stimulus, result
// back-pressure and the verdict. Uses pli_pkg, both interfaces and pli_list_checker.
module tb_positional_list_insert_delete;

    localparam int HALF_PERIOD = 4;
    // Well above the slowest sane run (every command a full 64-entry display behind
    // a half-idle receiver).
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 150;

    logic clk = 1'b0;
    logic rst_n;

    pli_cmd_if cmd ();
    pli_rsp_if rsp ();

    int fail_count;
    int outstanding;
    int results_checked;

    // idle percentages for the sender and the receiver, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    // bumping this asks the receiver process for one long hold-off
    int hold_req;
    // length the list should have; used to aim positions at valid ranges and to fill the list
    int list_len;
    int sent_count;
    int cycle_count;

    positional_list_insert_delete uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    pli_list_checker checker_inst
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rsp             (rsp),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** positional_list_insert_delete: FAILED **");
        $finish;
    end

    // Result side: random back-pressure plus the long hold-off on request. The
    // hold counter lives here so the sender keeps pushing while it runs down.
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Extremes show up often so the sign bit and all-ones patterns get exercised.
    function automatic logic signed [pli_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // One command transaction: optional random gap, then hold valid until accepted.
    // valid is left high afterwards so back-to-back commands need no extra NBA.
    task automatic send_cmd(input logic [pli_pkg::OP_W-1:0] op,
                            input logic [pli_pkg::POS_W-1:0] pos,
                            input logic signed [pli_pkg::DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.opcode   <= op;
        cmd.position <= pos;
        cmd.value    <= val;
        do
            @(posedge clk);
        while (!cmd.ready);
        sent_count++;
        // track the length so later positions land where they are meant to
        if (op == pli_pkg::OP_INSERT && pos <= list_len && list_len < pli_pkg::DEPTH)
            list_len++;
        else if (op == pli_pkg::OP_DELETE && pos < list_len)
            list_len--;
    endtask

    // Random command; noise_pct of them get a position from the whole field,
    // the rest a position that is valid for the current length where one exists.
    task automatic random_cmd(input int w_ins, input int w_del, input int w_upd,
                              input int noise_pct);
        int unsigned               roll;
        logic [pli_pkg::OP_W-1:0]  op;
        logic [pli_pkg::POS_W-1:0] pos;
        roll = $urandom_range(99);
        if (roll < w_ins)
            op = pli_pkg::OP_INSERT;
        else if (roll < w_ins + w_del)
            op = pli_pkg::OP_DELETE;
        else if (roll < w_ins + w_del + w_upd)
            op = pli_pkg::OP_UPDATE;
        else
            op = pli_pkg::OP_DISPLAY;
        if ($urandom_range(99) < noise_pct)
            pos = pli_pkg::POS_W'($urandom_range(127));
        else if (op == pli_pkg::OP_INSERT)
            pos = pli_pkg::POS_W'($urandom_range(list_len));
        else if (list_len == 0)
            pos = pli_pkg::POS_W'($urandom_range(127));
        else
            pos = pli_pkg::POS_W'($urandom_range(list_len - 1));
        send_cmd(op, pos, pick_value());
    endtask

    // Drop valid and wait until every predicted result has been seen.
    task automatic drain_results();
        cmd.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        cmd.valid     = 1'b0;
        cmd.opcode    = pli_pkg::OP_INSERT;
        cmd.position  = '0;
        cmd.value     = '0;
        rst_n         = 1'b0;
        hold_req      = 0;
        list_len      = 0;
        sent_count    = 0;
        send_idle_pct = 8;
        recv_idle_pct = 50;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: empty list, bad positions, value extremes ----
        send_cmd(pli_pkg::OP_DISPLAY, 7'd0,   '0);             // empty display
        send_cmd(pli_pkg::OP_DELETE,  7'd0,   '0);             // delete on empty list
        send_cmd(pli_pkg::OP_UPDATE,  7'd0,   '1);             // update on empty list
        send_cmd(pli_pkg::OP_INSERT,  7'd1,   '0);             // insert past the end
        send_cmd(pli_pkg::OP_INSERT,  7'd0,   32'sh7FFF_FFFF);
        send_cmd(pli_pkg::OP_INSERT,  7'd1,   32'sh8000_0000); // append at the count
        send_cmd(pli_pkg::OP_INSERT,  7'd0,   '1);             // insert at head
        send_cmd(pli_pkg::OP_INSERT,  7'd1,   '0);             // insert in the middle
        send_cmd(pli_pkg::OP_INSERT,  7'd127, '0);             // every position bit high
        send_cmd(pli_pkg::OP_UPDATE,  7'd3,   32'sh5555_5555); // update the tail
        send_cmd(pli_pkg::OP_UPDATE,  7'd4,   '0);             // update at the count
        send_cmd(pli_pkg::OP_UPDATE,  7'd0,   32'shAAAA_AAAA); // update the head
        send_cmd(pli_pkg::OP_DISPLAY, 7'd0,   '0);
        send_cmd(pli_pkg::OP_DELETE,  7'd4,   '0);             // delete at the count
        send_cmd(pli_pkg::OP_DELETE,  7'd3,   '0);             // delete the tail
        send_cmd(pli_pkg::OP_DELETE,  7'd0,   '0);             // delete the head
        send_cmd(pli_pkg::OP_DELETE,  7'd64,  '0);
        send_cmd(pli_pkg::OP_DISPLAY, 7'd127, '1);             // display ignores its fields
        send_cmd(pli_pkg::OP_INSERT,  7'd2,   32'sh1234_5678);
        send_cmd(pli_pkg::OP_DISPLAY, 7'd0,   '0);

        // ---- random edits, leaning toward growth ----
        repeat (12) random_cmd(50, 20, 15, 15);

        // ---- receiver holds off for a long stretch while commands keep coming ----
        hold_req <= hold_req + 1;
        repeat (10) random_cmd(30, 10, 10, 10);
        // sender pauses here until the block has answered everything
        drain_results();

        // ---- fill to capacity, then hit the full-list paths ----
        send_idle_pct = 50;
        recv_idle_pct = 8;
        while (list_len < pli_pkg::DEPTH)
            send_cmd(pli_pkg::OP_INSERT, pli_pkg::POS_W'($urandom_range(list_len)),
                     pick_value());
        send_cmd(pli_pkg::OP_INSERT,  pli_pkg::POS_W'(pli_pkg::DEPTH),
                 32'sh0F0F_0F0F);                                       // full, append
        send_cmd(pli_pkg::OP_INSERT,  7'd0, 32'sh7FFF_FFFF);            // full, at head
        send_cmd(pli_pkg::OP_INSERT,  pli_pkg::POS_W'(pli_pkg::DEPTH + 1),
                 '0);                                                   // bad beats full
        send_cmd(pli_pkg::OP_UPDATE,  pli_pkg::POS_W'(pli_pkg::DEPTH - 1), 32'sh8000_0000);
        send_cmd(pli_pkg::OP_DISPLAY, 7'd0, '0);                        // longest display
        send_cmd(pli_pkg::OP_DELETE,  pli_pkg::POS_W'(pli_pkg::DEPTH - 1), '0);
        send_cmd(pli_pkg::OP_UPDATE,  pli_pkg::POS_W'(pli_pkg::DEPTH - 1),
                 '0);                                                   // now past the end
        drain_results();

        // ---- back-to-back, no idling on either side, shrinking the list ----
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) random_cmd(20, 45, 15, 10);
        send_cmd(pli_pkg::OP_DISPLAY, 7'd0, '0);
        drain_results();

        // let any stray result surface before the verdict
        repeat (10) @(posedge clk);

        $display("Ran %0d command transactions: empty, bad-position, full-list, update and",
                 sent_count);
        $display("display cases at up to %0d entries; %0d results checked, %0d errors",
                 pli_pkg::DEPTH, results_checked, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("** positional_list_insert_delete: PASSED **");
        else
            $display("** positional_list_insert_delete: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
sv/pli_pkg.sv
sv/pli_cmd_if.sv
sv/pli_rsp_if.sv
sv/pli_cell.sv
sv/positional_list_insert_delete.sv
sv/pli_checker.sv
sim/pli_list_checker.sv
sim/tb_positional_list_insert_delete.sv
